/* src/sqp_pkg.sv */
// Shared types and constants of the sorted priority queue.
package sqp_pkg;

   localparam int DEF_CAPACITY = 16;
   localparam int DATA_W = 32;

   typedef enum logic [1:0] {
      CMD_INSERT = 2'd0,
      CMD_PEEK   = 2'd1,
      CMD_DUMP   = 2'd2
   } cmd_type;

   typedef enum logic [1:0] {
      ST_OK    = 2'd0,
      ST_FULL  = 2'd1,
      ST_EMPTY = 2'd2
   } status_type;

   typedef enum logic [1:0] {
      OP_HOLD,
      OP_INSERT,
      OP_ROTATE
   } cell_op_type;

   typedef struct packed {
      logic                     valid;
      logic signed [DATA_W-1:0] val;
      logic signed [DATA_W-1:0] prio;
   } entry_type;

   typedef struct packed {
      cell_op_type              op;
      logic signed [DATA_W-1:0] ins_val;
      logic signed [DATA_W-1:0] ins_prio;
   } cell_ctl_type;

endpackage

/* src/sqp_if.sv */
// Request and response channel interfaces of the sorted priority queue.
interface sqp_req_if
   import sqp_pkg::*;
   ();
   logic                     valid;
   logic                     ready;
   logic [1:0]               command;
   logic signed [DATA_W-1:0] item_value;
   logic signed [DATA_W-1:0] item_priority;

   modport source (output valid, command, item_value, item_priority, input ready);
   modport sink (input valid, command, item_value, item_priority, output ready);
endinterface

interface sqp_rsp_if
   import sqp_pkg::*;
   ();
   logic                     valid;
   logic                     ready;
   logic [1:0]               status;
   logic signed [DATA_W-1:0] entry_value;
   logic signed [DATA_W-1:0] entry_priority;
   logic                     last;

   modport source (output valid, status, entry_value, entry_priority, last, input ready);
   modport sink (input valid, status, entry_value, entry_priority, last, output ready);
endinterface

/* src/sqp_cell.sv */
// One storage cell of the sorted chain: holds an entry, inserts or rotates.
module sqp_cell
   import sqp_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   input  cell_ctl_type ctl,
   input  entry_type    left,
   input  logic         left_keep,
   input  entry_type    right,
   input  entry_type    head,
   output logic         keep,
   output entry_type    q
);

   entry_type q_ff;
   entry_type q_in;

   // A cell keeps its entry when it already ranks at or above the new one.
   assign keep = q_ff.valid && (q_ff.prio >= ctl.ins_prio);
   assign q = q_ff;

   always_comb begin
      q_in = q_ff;
      unique case (ctl.op)
         OP_INSERT: begin
            if (!keep) begin
               if (left_keep) begin
                  q_in.valid = 1'b1;
                  q_in.val   = ctl.ins_val;
                  q_in.prio  = ctl.ins_prio;
               end else begin
                  q_in = left;
               end
            end
         end
         OP_ROTATE: begin
            // The last occupied cell wraps around to the head entry.
            if (q_ff.valid) begin
               if (right.valid) begin
                  q_in = right;
               end else begin
                  q_in = head;
               end
            end
         end
         default: q_in = q_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         q_ff.valid <= 1'b0;
      end else begin
         q_ff.valid <= q_in.valid;
      end
      q_ff.val  <= q_in.val;
      q_ff.prio <= q_in.prio;
   end

endmodule

/* src/sorted_priority_queue_core.sv */
// Top level of the sorted priority queue: cell chain, command control and response word.
// Entries live in a chain of CAPACITY cells kept in descending priority order, with
// equal priorities in arrival order. An insert or a peek is taken whenever the response slot
// is free, and one can follow every cycle while the response word is being taken; an insert
// into a full queue is dropped with a full status. A dump rotates the chain by one cell
// per cycle while response words are taken and returns one word per stored entry, top
// first, holding the request side until the last entry's word is loaded (longer when the
// response side stalls); a dump of an empty queue returns one empty-status word. Command
// code 3 is accepted and produces nothing. No clearing pass is needed after reset.
module sorted_priority_queue_core
   import sqp_pkg::*;
#(
   parameter int CAPACITY = DEF_CAPACITY
)
(
   input logic      clock,
   input logic      reset,
   sqp_req_if.sink  req_bus,
   sqp_rsp_if.source rsp_bus
);

   localparam int CNT_W = $clog2(CAPACITY + 1);

   typedef enum logic {
      S_IDLE,
      S_DUMP
   } state_type;

   state_type                state_ff;
   logic [CNT_W-1:0]         count_ff;
   logic [CNT_W-1:0]         remain_ff;
   logic                     rsp_valid_ff;
   logic [1:0]               rsp_status_ff;
   logic signed [DATA_W-1:0] rsp_value_ff;
   logic signed [DATA_W-1:0] rsp_prio_ff;
   logic                     rsp_last_ff;

   cell_ctl_type ctl;
   entry_type    cell_q [CAPACITY];
   logic         cell_keep [CAPACITY];
   entry_type    head;
   logic         out_free;
   logic         req_fire;
   logic         rsp_load;
   logic         full;
   logic         empty;

   assign head     = cell_q[0];
   assign full     = cell_q[CAPACITY-1].valid;
   assign empty    = !head.valid;
   assign out_free = !rsp_valid_ff || rsp_bus.ready;
   assign req_bus.ready = (state_ff == S_IDLE) && out_free;
   assign req_fire = req_bus.valid && req_bus.ready;

   // A new response word is loaded for an insert, a peek, an empty dump or a dump step.
   assign rsp_load = (req_fire && ((req_bus.command == CMD_INSERT) ||
                                   (req_bus.command == CMD_PEEK) ||
                                   ((req_bus.command == CMD_DUMP) && empty))) ||
                     ((state_ff == S_DUMP) && out_free);

   always_comb begin
      ctl.op       = OP_HOLD;
      ctl.ins_val  = req_bus.item_value;
      ctl.ins_prio = req_bus.item_priority;
      if (req_fire && (req_bus.command == CMD_INSERT) && !full) begin
         ctl.op = OP_INSERT;
      end else if ((state_ff == S_DUMP) && out_free) begin
         ctl.op = OP_ROTATE;
      end
   end

   for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
      entry_type left;
      entry_type right;
      logic      left_keep;

      if (i == 0) begin : g_first
         assign left      = '0;
         assign left_keep = 1'b1;
      end else begin : g_inner
         assign left      = cell_q[i-1];
         assign left_keep = cell_keep[i-1];
      end

      if (i == CAPACITY - 1) begin : g_tail
         assign right = '0;
      end else begin : g_body
         assign right = cell_q[i+1];
      end

      sqp_cell u_cell (
         .clock     (clock),
         .reset     (reset),
         .ctl       (ctl),
         .left      (left),
         .left_keep (left_keep),
         .right     (right),
         .head      (head),
         .keep      (cell_keep[i]),
         .q         (cell_q[i])
      );
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= S_IDLE;
         count_ff      <= '0;
         remain_ff     <= '0;
         rsp_valid_ff  <= 1'b0;
         rsp_status_ff <= ST_OK;
         rsp_value_ff  <= '0;
         rsp_prio_ff   <= '0;
         rsp_last_ff   <= 1'b0;
      end else begin
         if (out_free) begin
            rsp_valid_ff <= rsp_load;
         end
         unique case (state_ff)
            S_IDLE: begin
               if (req_fire) begin
                  unique case (req_bus.command)
                     CMD_INSERT: begin
                        rsp_status_ff <= full ? ST_FULL : ST_OK;
                        rsp_value_ff  <= '0;
                        rsp_prio_ff   <= '0;
                        rsp_last_ff   <= 1'b1;
                        if (!full) begin
                           count_ff <= count_ff + 1'b1;
                        end
                     end
                     CMD_PEEK: begin
                        rsp_status_ff <= empty ? ST_EMPTY : ST_OK;
                        rsp_value_ff  <= empty ? '0 : head.val;
                        rsp_prio_ff   <= empty ? '0 : head.prio;
                        rsp_last_ff   <= 1'b1;
                     end
                     CMD_DUMP: begin
                        if (empty) begin
                           rsp_status_ff <= ST_EMPTY;
                           rsp_value_ff  <= '0;
                           rsp_prio_ff   <= '0;
                           rsp_last_ff   <= 1'b1;
                        end else begin
                           state_ff  <= S_DUMP;
                           remain_ff <= count_ff;
                        end
                     end
                     default: begin
                     end
                  endcase
               end
            end
            S_DUMP: begin
               // Each free response slot takes the head entry while the chain rotates.
               if (out_free) begin
                  rsp_status_ff <= ST_OK;
                  rsp_value_ff  <= head.val;
                  rsp_prio_ff   <= head.prio;
                  rsp_last_ff   <= (remain_ff == CNT_W'(1));
                  remain_ff     <= remain_ff - 1'b1;
                  if (remain_ff == CNT_W'(1)) begin
                     state_ff <= S_IDLE;
                  end
               end
            end
            default: state_ff <= S_IDLE;
         endcase
      end
   end

   assign rsp_bus.valid          = rsp_valid_ff;
   assign rsp_bus.status         = rsp_status_ff;
   assign rsp_bus.entry_value    = rsp_value_ff;
   assign rsp_bus.entry_priority = rsp_prio_ff;
   assign rsp_bus.last           = rsp_last_ff;

endmodule

/* src/sqp_checker.sv */
// Port-level checks of the sorted priority queue and their binding to the top level.
module sqp_assertions
   import sqp_pkg::*;
(
   input logic                     clock,
   input logic                     reset,
   input logic                     req_valid,
   input logic                     req_ready,
   input logic [1:0]               req_command,
   input logic                     rsp_valid,
   input logic                     rsp_ready,
   input logic [1:0]               rsp_status,
   input logic signed [DATA_W-1:0] rsp_entry_value,
   input logic signed [DATA_W-1:0] rsp_entry_priority,
   input logic                     rsp_last
);

   // A stalled response word stays put.
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_status) &&
         $stable(rsp_entry_value) && $stable(rsp_entry_priority) && $stable(rsp_last))
      else $error("stalled response word changed");

   a_full_word: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_status == ST_FULL) |->
         rsp_last && (rsp_entry_value == 0) && (rsp_entry_priority == 0))
      else $error("full status word is malformed");

   a_empty_word: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_status == ST_EMPTY) |->
         rsp_last && (rsp_entry_value == 0) && (rsp_entry_priority == 0))
      else $error("empty status word is malformed");

   // Only a dump produces words that are not the final one, and those carry entries.
   a_mid_ok: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_last |-> (rsp_status == ST_OK))
      else $error("non-final word without ok status");

   a_single_reply: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready && ((req_command == CMD_INSERT) || (req_command == CMD_PEEK))
         |=> rsp_valid && rsp_last)
      else $error("insert or peek produced no response word");

endmodule

bind sorted_priority_queue_core sqp_assertions u_sqp_assertions (
   .clock              (clock),
   .reset              (reset),
   .req_valid          (req_bus.valid),
   .req_ready          (req_bus.ready),
   .req_command        (req_bus.command),
   .rsp_valid          (rsp_bus.valid),
   .rsp_ready          (rsp_bus.ready),
   .rsp_status         (rsp_bus.status),
   .rsp_entry_value    (rsp_bus.entry_value),
   .rsp_entry_priority (rsp_bus.entry_priority),
   .rsp_last           (rsp_bus.last)
);

/* bench/sqp_checker.sv */
`timescale 1ns / 1ps
// Checker for the sorted priority queue: predicts every response word and compares it.
module sqp_checker
   import sqp_pkg::*;
#(
   parameter int CAPACITY = DEF_CAPACITY
)
(
   input logic clock,
   input logic reset,
   sqp_req_if  req_mon,
   sqp_rsp_if  rsp_mon,
   output int  mismatch_count,
   output int  words_pending
);

   typedef struct {
      status_type               status;
      logic signed [DATA_W-1:0] value;
      logic signed [DATA_W-1:0] prio;
      logic                     last;
   } queue_word_type;

   logic signed [DATA_W-1:0] slot_value [CAPACITY];
   logic signed [DATA_W-1:0] slot_prio [CAPACITY];
   int                       slot_count;
   queue_word_type           expected_words [$];

   initial begin
      mismatch_count = 0;
      words_pending = 0;
      slot_count = 0;
   end

   function automatic queue_word_type make_word(input status_type status,
                                                input logic signed [DATA_W-1:0] value,
                                                input logic signed [DATA_W-1:0] prio,
                                                input logic last);
      queue_word_type w;
      w.status = status;
      w.value = value;
      w.prio = prio;
      w.last = last;
      return w;
   endfunction

   // Applies one accepted request to the predicted store and queues the words it causes.
   task automatic predict_queue_command(input logic [1:0] command,
                                        input logic signed [DATA_W-1:0] value,
                                        input logic signed [DATA_W-1:0] prio);
      int pos;
      int idx;
      case (command)
         CMD_INSERT: begin
            if (slot_count >= CAPACITY) begin
               expected_words.push_back(make_word(ST_FULL, '0, '0, 1'b1));
            end else begin
               // A new entry goes behind every entry of equal or higher priority.
               pos = 0;
               while (pos < slot_count && slot_prio[pos] >= prio) pos++;
               for (idx = slot_count; idx > pos; idx--) begin
                  slot_value[idx] = slot_value[idx-1];
                  slot_prio[idx] = slot_prio[idx-1];
               end
               slot_value[pos] = value;
               slot_prio[pos] = prio;
               slot_count++;
               expected_words.push_back(make_word(ST_OK, '0, '0, 1'b1));
            end
         end
         CMD_PEEK: begin
            if (slot_count == 0)
               expected_words.push_back(make_word(ST_EMPTY, '0, '0, 1'b1));
            else
               expected_words.push_back(make_word(ST_OK, slot_value[0], slot_prio[0], 1'b1));
         end
         CMD_DUMP: begin
            if (slot_count == 0) begin
               expected_words.push_back(make_word(ST_EMPTY, '0, '0, 1'b1));
            end else begin
               for (idx = 0; idx < slot_count; idx++)
                  expected_words.push_back(make_word(ST_OK, slot_value[idx], slot_prio[idx],
                                                     idx == slot_count - 1));
            end
         end
         default: begin
            // The unused command code leaves the store alone and returns nothing.
         end
      endcase
   endtask

   always @(posedge clock) begin
      queue_word_type want;
      if (reset) begin
         slot_count = 0;
         expected_words.delete();
         words_pending <= 0;
      end else begin
         // The request goes first, in case its word is taken at the same edge.
         if (req_mon.valid === 1'b1 && req_mon.ready === 1'b1)
            predict_queue_command(req_mon.command, req_mon.item_value, req_mon.item_priority);
         if (rsp_mon.valid === 1'b1 && rsp_mon.ready === 1'b1) begin
            if (expected_words.size() == 0) begin
               $error("unexpected response word: status %0d, value %0d, priority %0d",
                      rsp_mon.status, rsp_mon.entry_value, rsp_mon.entry_priority);
               mismatch_count++;
            end else begin
               want = expected_words.pop_front();
               if (rsp_mon.status !== want.status) begin
                  $error("status: expected %0d, got %0d", want.status, rsp_mon.status);
                  mismatch_count++;
               end
               if (rsp_mon.entry_value !== want.value) begin
                  $error("entry_value: expected %0d, got %0d", want.value,
                         rsp_mon.entry_value);
                  mismatch_count++;
               end
               if (rsp_mon.entry_priority !== want.prio) begin
                  $error("entry_priority: expected %0d, got %0d", want.prio,
                         rsp_mon.entry_priority);
                  mismatch_count++;
               end
               if (rsp_mon.last !== want.last) begin
                  $error("last: expected %0d, got %0d", want.last, rsp_mon.last);
                  mismatch_count++;
               end
            end
         end
         words_pending <= expected_words.size();
      end
   end

endmodule

/* bench/tb.sv */
`timescale 1ns / 1ps
// Top of the sorted priority queue testbench: clock, reset, stimulus and verdict.
module tb;
   import sqp_pkg::*;

   localparam logic [1:0] CMD_UNUSED = 2'd3;
   localparam int IDLE_PCT = 38;
   localparam int LONG_STALL = 120;
   localparam int DRAIN_CYCLES = 40;
   localparam int RANDOM_ITEMS = 356;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic calm = 1'b0;
   logic stall_toggle = 1'b0;
   logic stall_seen = 1'b0;
   int   stall_left = 0;
   int   mismatch_count;
   int   words_pending;

   sqp_req_if req_bus ();
   sqp_rsp_if rsp_bus ();

   sorted_priority_queue_core #(
      .CAPACITY(DEF_CAPACITY)
   ) u_dut (
      .clock   (clock),
      .reset   (reset),
      .req_bus (req_bus),
      .rsp_bus (rsp_bus)
   );

   sqp_checker #(
      .CAPACITY(DEF_CAPACITY)
   ) u_checker (
      .clock          (clock),
      .reset          (reset),
      .req_mon        (req_bus),
      .rsp_mon        (rsp_bus),
      .mismatch_count (mismatch_count),
      .words_pending  (words_pending)
   );

   always #5 clock = ~clock;

   initial begin
      #2_000_000;
      $display("*** FAILED ***");
      $finish;
   end

   // Response side: random stalls, none while calm, and a long hold-off on request.
   always @(posedge clock) begin
      if (stall_toggle != stall_seen) begin
         stall_seen <= stall_toggle;
         stall_left <= LONG_STALL;
         rsp_bus.ready <= 1'b0;
      end else if (stall_left > 0) begin
         stall_left <= stall_left - 1;
         rsp_bus.ready <= 1'b0;
      end else begin
         rsp_bus.ready <= calm || ($urandom_range(99) >= IDLE_PCT);
      end
   end

   task automatic send_request_word(input logic [1:0] command,
                                    input logic signed [DATA_W-1:0] value,
                                    input logic signed [DATA_W-1:0] prio);
      while (!calm && $urandom_range(99) < IDLE_PCT) begin
         req_bus.valid <= 1'b0;
         @(posedge clock);
      end
      req_bus.valid <= 1'b1;
      req_bus.command <= command;
      req_bus.item_value <= value;
      req_bus.item_priority <= prio;
      @(posedge clock);
      while (req_bus.ready !== 1'b1) @(posedge clock);
   endtask

   // Drops the request side and waits until every predicted word has come back.
   task automatic wait_drained();
      req_bus.valid <= 1'b0;
      @(posedge clock);
      while (words_pending != 0) @(posedge clock);
   endtask

   // Half the picks are nearby priorities from -2 to 2 so that ties are common, plus extremes and noise.
   function automatic logic signed [DATA_W-1:0] pick_priority();
      int pick;
      pick = $urandom_range(3);
      case (pick)
         0, 1: return $urandom_range(4) - 2;
         2: return $urandom_range(1) ? 32'sh7fffffff : 32'sh80000000;
         default: return $urandom();
      endcase
   endfunction

   function automatic logic [1:0] pick_command();
      int roll;
      roll = $urandom_range(99);
      if (roll < 40) return CMD_INSERT;
      if (roll < 70) return CMD_PEEK;
      if (roll < 92) return CMD_DUMP;
      return CMD_UNUSED;
   endfunction

   initial begin
      int         sent;
      int         step;
      logic [1:0] command;
      req_bus.valid = 1'b0;
      req_bus.command = CMD_INSERT;
      req_bus.item_value = '0;
      req_bus.item_priority = '0;
      rsp_bus.ready = 1'b0;
      repeat (6) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Empty store, the unused code, then inserts covering extremes and ties.
      send_request_word(CMD_PEEK, '0, '0);
      send_request_word(CMD_DUMP, '0, '0);
      send_request_word(CMD_UNUSED, $urandom(), $urandom());
      send_request_word(CMD_INSERT, 32'sh7fffffff, 32'sd0);
      send_request_word(CMD_INSERT, 32'sh80000000, 32'sh7fffffff);
      send_request_word(CMD_INSERT, -32'sd1, 32'sh80000000);
      send_request_word(CMD_PEEK, '0, '0);
      send_request_word(CMD_INSERT, 32'sd1, -32'sd1);
      send_request_word(CMD_INSERT, 32'sd2, 32'sd1);
      send_request_word(CMD_INSERT, 32'sd3, 32'sd0);
      send_request_word(CMD_INSERT, 32'sd4, 32'sh7fffffff);
      send_request_word(CMD_PEEK, '0, '0);
      send_request_word(CMD_DUMP, '0, '0);
      send_request_word(CMD_UNUSED, $urandom(), $urandom());
      send_request_word(CMD_DUMP, '0, '0);
      wait_drained();

      sent = 0;
      step = 0;
      while (sent < RANDOM_ITEMS) begin
         if (step == 120) begin
            // Long response hold-off while requests keep coming with no gaps.
            stall_toggle <= ~stall_toggle;
            calm <= 1'b1;
         end
         if (step == 170) calm <= 1'b0;
         if (step == 250) wait_drained();
         if (step == 280) calm <= 1'b1;
         if (step == 330) calm <= 1'b0;
         command = pick_command();
         send_request_word(command, $urandom(), pick_priority());
         sent++;
         step++;
      end

      wait_drained();
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (mismatch_count == 0 && words_pending == 0)
         $display("*** PASSED ***");
      else
         $display("*** FAILED ***");
      $finish;
   end

endmodule
